// ===== rtl/mips_subset_execute_unit_defines.svh =====
`ifndef MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH

// concurrent check on an explicit clock and active-low reset
`define MSE_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check on the project clock and reset
`define MSE_ASSERT(name, prop, msg) \
  `MSE_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/mse_pkg.sv =====
`default_nettype none

package mse_pkg;

  localparam int unsigned XLEN               = 32;
  localparam int unsigned NUM_REGS           = 32;
  localparam int unsigned REG_AW             = 5;
  localparam int unsigned LADDR_W            = 10;
  localparam int unsigned NUM_LANES          = 4;
  localparam int unsigned LANE_W             = 2;
  localparam int unsigned DATA_BYTES_DEFAULT = 1024;

  localparam logic [REG_AW-1:0] REG_SP         = 5'd29;
  localparam logic [REG_AW-1:0] REG_RA         = 5'd31;
  localparam logic [XLEN-1:0]   PC_REGION_MASK = 32'hF000_0000;

  typedef enum logic {
    CFG_START_PC  = 1'b0,
    CFG_STACK_PTR = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_EXEC    = 1'b0,
    CMD_PRELOAD = 1'b1
  } cmd_e;

  typedef enum logic [5:0] {
    OP_SPECIAL = 6'h00,
    OP_J       = 6'h02,
    OP_JAL     = 6'h03,
    OP_BEQ     = 6'h04,
    OP_BNE     = 6'h05,
    OP_BGTZ    = 6'h07,
    OP_ADDI    = 6'h08,
    OP_ADDIU   = 6'h09,
    OP_SLTI    = 6'h0A,
    OP_ANDI    = 6'h0C,
    OP_ORI     = 6'h0D,
    OP_NORI    = 6'h0E,
    OP_LUI     = 6'h0F,
    OP_LB      = 6'h20,
    OP_LH      = 6'h21,
    OP_LW      = 6'h23,
    OP_LBU     = 6'h24,
    OP_LHU     = 6'h25,
    OP_SB      = 6'h28,
    OP_SH      = 6'h29,
    OP_SW      = 6'h2B,
    OP_HALT    = 6'h3F
  } opcode_e;

  typedef enum logic [5:0] {
    FN_SLL  = 6'h00,
    FN_SRL  = 6'h02,
    FN_SRA  = 6'h03,
    FN_JR   = 6'h08,
    FN_ADD  = 6'h20,
    FN_ADDU = 6'h21,
    FN_SUB  = 6'h22,
    FN_AND  = 6'h24,
    FN_OR   = 6'h25,
    FN_XOR  = 6'h26,
    FN_NOR  = 6'h27,
    FN_NAND = 6'h28,
    FN_SLT  = 6'h2A
  } funct_e;

  // value is the index of the last byte of the access
  typedef enum logic [1:0] {
    MS_BYTE = 2'd0,
    MS_HALF = 2'd1,
    MS_WORD = 2'd3
  } msize_e;

  typedef struct packed {
    logic               command;
    logic [XLEN-1:0]    instruction;
    logic [LADDR_W-1:0] load_address;
    logic [XLEN-1:0]    load_word;
  } in_req_t;

  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic              halted;
    logic              wrote_register;
    logic [REG_AW-1:0] written_index;
    logic [XLEN-1:0]   written_value;
  } out_req_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] idx;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  typedef struct packed {
    logic                 rd_en;
    logic [NUM_LANES-1:0] wr_en;
  } dmem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/mse_regfile.sv =====
`default_nettype none
`include "mips_subset_execute_unit_defines.svh"

module mse_regfile import mse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [REG_AW-1:0] rd_a_idx_i,
  input  logic [REG_AW-1:0] rd_b_idx_i,
  input  rf_wr_t            wr_i,
  output logic [XLEN-1:0]   rd_a_data_o,
  output logic [XLEN-1:0]   rd_b_data_o
);

  logic [XLEN-1:0]     mem_q [NUM_REGS];
  logic [NUM_REGS-1:0] valid_q, valid_d;
  logic                rd_a_vld_q, rd_b_vld_q;
  logic [XLEN-1:0]     rd_a_q, rd_b_q;

  // never-written entries read as zero
  always_comb begin
    valid_d = valid_q;
    if (wr_i.en) begin
      valid_d[wr_i.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (rd_en_i) begin
        rd_a_vld_q <= valid_q[rd_a_idx_i];
        rd_b_vld_q <= valid_q[rd_b_idx_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_a_idx_i];
      rd_b_q <= mem_q[rd_b_idx_i];
    end
  end

  assign rd_a_data_o = rd_a_vld_q ? rd_a_q : '0;
  assign rd_b_data_o = rd_b_vld_q ? rd_b_q : '0;

  `MSE_ASSERT(a_no_zero_reg_write, wr_i.en |-> (wr_i.idx != '0), "register zero written")

endmodule

`default_nettype wire

// ===== rtl/mse_dmem.sv =====
`default_nettype none
`include "mips_subset_execute_unit_defines.svh"

module mse_dmem import mse_pkg::*; #(
  parameter int unsigned DATA_BYTES = DATA_BYTES_DEFAULT
) (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  dmem_ctl_t                                               ctl_i,
  input  logic [NUM_LANES-1:0][$clog2(DATA_BYTES/NUM_LANES)-1:0] row_i,
  input  logic [NUM_LANES-1:0][7:0]                               wdata_i,
  output logic [NUM_LANES-1:0][7:0]                               rdata_o,
  output logic                                                    clr_busy_o
);

  localparam int unsigned     ROWS     = DATA_BYTES / NUM_LANES;
  localparam int unsigned     RW       = $clog2(ROWS);
  localparam logic [RW-1:0]   LAST_ROW = RW'(ROWS - 1);

  // one byte bank per lane, byte address a lives in bank a%4, row a/4
  logic [7:0]                       bank_q [NUM_LANES][ROWS];
  logic [NUM_LANES-1:0][7:0]        rdata_q;
  logic                             clr_busy_q, clr_busy_d;
  logic [RW-1:0]                    clr_row_q, clr_row_d;
  logic [NUM_LANES-1:0]             we;
  logic [NUM_LANES-1:0][RW-1:0]     row;
  logic [NUM_LANES-1:0][7:0]        wdata;

  // clearing sweep after reset, one row of all banks per cycle
  always_comb begin
    clr_busy_d = clr_busy_q && (clr_row_q != LAST_ROW);
    clr_row_d  = clr_busy_q ? clr_row_q + RW'(1) : clr_row_q;
  end

  always_comb begin
    if (clr_busy_q) begin
      we    = '1;
      wdata = '0;
      for (int k = 0; k < NUM_LANES; k++) begin
        row[k] = clr_row_q;
      end
    end else begin
      we    = ctl_i.wr_en;
      wdata = wdata_i;
      row   = row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_row_q  <= clr_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_LANES; k++) begin
      if (we[k]) begin
        bank_q[k][row[k]] <= wdata[k];
      end
      if (ctl_i.rd_en) begin
        rdata_q[k] <= bank_q[k][row[k]];
      end
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

  `MSE_ASSERT(a_clear_covers_all_rows, $fell(clr_busy_q) |-> ($past(clr_row_q) == LAST_ROW), "clear sweep ended early")

endmodule

`default_nettype wire

// ===== rtl/mips_subset_execute_unit.sv =====
// Execute unit for a MIPS-like integer subset with its own register file and data memory.
// Request channel: in_valid_i / in_stall_o / in_req_i. A request is taken at a clock edge
// with valid high and stall low. command 0 executes the instruction fetched at the
// current program counter, command 1 preloads one data word into memory.
// Result channel: out_valid_o / out_stall_i / out_req_o, one result per request, in order.
// Config port: cfg_we_i, cfg_idx_i, cfg_data_i; index 0 sets the program counter and
// restarts a halted unit, index 1 loads register 29. Write it only while the unit is idle.
// Pipeline: two stages, register read and execute, then data memory read and write-back.
// Throughput: one request per cycle unless a stalled result holds the execute stage.
// Register file (two read ports, one write port) and the four byte banks of the data
// memory each take one access per cycle; write-back results and load data are forwarded
// to the next request, so no bubbles are needed.
// Reset: the data memory is cleared by a sweep over all rows (one row of the four banks
// per cycle); in_stall_o stays high until it is done. DATA_BYTES must be a power of
// two. Register file clears at once.
// A stalled result holds in the output stage; a new request is still taken as long as
// the execute stage can move or is empty.
`default_nettype none
`include "mips_subset_execute_unit_defines.svh"

module mips_subset_execute_unit import mse_pkg::*; #(
  parameter int unsigned DATA_BYTES = DATA_BYTES_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_req_t         in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_req_t        out_req_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [XLEN-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(DATA_BYTES);
  localparam int unsigned RW = AW - LANE_W;

  // ---------------------------------------------------------------- helpers
  function automatic logic [XLEN-1:0] sext16(input logic [15:0] v);
    return {{(XLEN-16){v[15]}}, v};
  endfunction

  function automatic logic lt_signed(input logic [XLEN-1:0] a, input logic [XLEN-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [XLEN-1:0] alu_r(input logic [5:0] fn, input logic [XLEN-1:0] a,
                                            input logic [XLEN-1:0] b, input logic [4:0] sh);
    logic [XLEN-1:0] r;
    unique case (fn) inside
      FN_ADD, FN_ADDU: r = a + b;
      FN_SUB:          r = a - b;
      FN_AND:          r = a & b;
      FN_OR:           r = a | b;
      FN_XOR:          r = a ^ b;
      FN_NOR:          r = ~(a | b);
      FN_NAND:         r = ~(a & b);
      FN_SLT:          r = XLEN'(lt_signed(a, b));
      FN_SLL:          r = b << sh;
      FN_SRL:          r = b >> sh;
      FN_SRA:          r = XLEN'($signed(b) >>> sh);
      default:         r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [XLEN-1:0] alu_i(input logic [5:0] op, input logic [XLEN-1:0] a,
                                            input logic [15:0] imm);
    logic [XLEN-1:0] r;
    unique case (op) inside
      OP_ADDI, OP_ADDIU: r = a + sext16(imm);
      OP_LUI:            r = {imm, {(XLEN-16){1'b0}}};
      OP_ANDI:           r = a & XLEN'(imm);
      OP_ORI:            r = a | XLEN'(imm);
      OP_NORI:           r = ~(a | XLEN'(imm));
      OP_SLTI:           r = XLEN'(lt_signed(a, sext16(imm)));
      default:           r = '0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- signals
  logic in_accept, out_accept, s1_adv, clr_busy;

  // architectural pc and halt flag
  logic [XLEN-1:0] pc_q, pc_d;
  logic            halt_q, halt_d;

  // execute stage
  logic            s1_vld_q, s1_vld_d;
  in_req_t         s1_req_q;

  // output stage
  logic              s2_vld_q, s2_vld_d;
  logic [XLEN-1:0]   s2_pc_q;
  logic              s2_halt_q;
  logic              s2_wr_q;
  logic [REG_AW-1:0] s2_idx_q;
  logic [XLEN-1:0]   s2_val_q;
  logic              s2_load_q;
  msize_e            s2_size_q;
  logic              s2_sign_q;
  logic [LANE_W-1:0] s2_off_q;

  // write that landed in the register file at the read edge of the execute item
  logic              byp_vld_q, byp_vld_d;
  logic [REG_AW-1:0] byp_idx_q;
  logic [XLEN-1:0]   byp_val_q;

  // register file and data memory ports
  rf_wr_t                         rf_wr;
  logic [XLEN-1:0]                rf_a_data, rf_b_data;
  dmem_ctl_t                      dm_ctl;
  logic [NUM_LANES-1:0][RW-1:0]   lane_row;
  logic [NUM_LANES-1:0][7:0]      lane_wdata;
  logic [NUM_LANES-1:0][7:0]      dm_rdata;
  logic [NUM_LANES-1:0]           lane_on;
  logic [NUM_LANES-1:0][LANE_W-1:0] lane_off, lane_sel;

  // decode fields
  logic [XLEN-1:0]   s1_ins;
  logic [5:0]        s1_op, s1_fn;
  logic [REG_AW-1:0] s1_rs, s1_rt, s1_rd;
  logic [4:0]        s1_sh;
  logic [15:0]       s1_imm;

  // execute results
  logic [XLEN-1:0]   opa, opb, imm_sx, pc4, ea, br_tgt, jmp_tgt;
  logic [XLEN-1:0]   npc, wval, maddr, sdata;
  logic              halt_nx, wr, ld, st, msign;
  logic [REG_AW-1:0] widx;
  msize_e            msize;

  // output-stage values
  logic [NUM_LANES-1:0][7:0] ld_byte;
  logic [XLEN-1:0]           ld_val, s2_res_val;

  // ---------------------------------------------------------------- handshake
  assign s1_adv     = s1_vld_q && (!s2_vld_q || out_accept);
  assign in_stall_o = clr_busy || (s1_vld_q && !s1_adv);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = s2_vld_q && !out_stall_i;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_comb begin
    s2_vld_d = s2_vld_q;
    if (s1_adv) begin
      s2_vld_d = 1'b1;
    end else if (out_accept) begin
      s2_vld_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------- register file
  // operands are read at the request edge; the execute stage patches them with
  // the pending write-back and with the write that hit the same edge
  mse_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_a_idx_i (in_req_i.instruction[25:21]),
    .rd_b_idx_i (in_req_i.instruction[20:16]),
    .wr_i       (rf_wr),
    .rd_a_data_o(rf_a_data),
    .rd_b_data_o(rf_b_data)
  );

  // single write port: config load of the stack pointer or write-back on result handoff
  always_comb begin
    if (cfg_we_i && (cfg_idx_i == CFG_STACK_PTR)) begin
      rf_wr.en   = 1'b1;
      rf_wr.idx  = REG_SP;
      rf_wr.data = cfg_data_i;
    end else begin
      rf_wr.en   = out_accept && s2_wr_q;
      rf_wr.idx  = s2_idx_q;
      rf_wr.data = s2_res_val;
    end
  end

  assign byp_vld_d = in_accept ? rf_wr.en : byp_vld_q;

  // ---------------------------------------------------------------- execute stage
  assign s1_ins = s1_req_q.instruction;
  assign s1_op  = s1_ins[31:26];
  assign s1_rs  = s1_ins[25:21];
  assign s1_rt  = s1_ins[20:16];
  assign s1_rd  = s1_ins[15:11];
  assign s1_sh  = s1_ins[10:6];
  assign s1_fn  = s1_ins[5:0];
  assign s1_imm = s1_ins[15:0];

  // forwarding: pending write-back first, then the same-edge write, then the file
  always_comb begin
    if (s2_vld_q && s2_wr_q && (s2_idx_q == s1_rs)) begin
      opa = s2_res_val;
    end else if (byp_vld_q && (byp_idx_q == s1_rs)) begin
      opa = byp_val_q;
    end else begin
      opa = rf_a_data;
    end
    if (s2_vld_q && s2_wr_q && (s2_idx_q == s1_rt)) begin
      opb = s2_res_val;
    end else if (byp_vld_q && (byp_idx_q == s1_rt)) begin
      opb = byp_val_q;
    end else begin
      opb = rf_b_data;
    end
  end

  assign imm_sx  = sext16(s1_imm);
  assign pc4     = pc_q + XLEN'(4);
  assign ea      = opa + imm_sx;
  assign br_tgt  = pc4 + {imm_sx[XLEN-3:0], 2'b00};
  assign jmp_tgt = (pc4 & PC_REGION_MASK) | {4'b0000, s1_ins[25:0], 2'b00};

  // instruction decode and execute
  always_comb begin
    npc     = pc_q;
    halt_nx = halt_q;
    wr      = 1'b0;
    widx    = '0;
    wval    = '0;
    ld      = 1'b0;
    st      = 1'b0;
    msize   = MS_WORD;
    msign   = 1'b0;
    maddr   = ea;
    sdata   = opb;
    // a halted unit ignores every request
    if (!halt_q) begin
      if (s1_req_q.command == CMD_PRELOAD) begin
        // preload ignores the two low address bits
        st    = 1'b1;
        maddr = XLEN'({s1_req_q.load_address[LADDR_W-1:2], 2'b00});
        sdata = s1_req_q.load_word;
      end else begin
        npc = pc4;
        unique case (s1_op) inside
          OP_HALT: begin
            halt_nx = 1'b1;
            npc     = pc_q;
          end
          OP_SPECIAL: begin
            if (s1_fn == FN_JR) begin
              npc = opa;
            end else begin
              wr   = 1'b1;
              widx = s1_rd;
              wval = alu_r(s1_fn, opa, opb, s1_sh);
            end
          end
          OP_J: begin
            npc = jmp_tgt;
          end
          OP_JAL: begin
            npc  = jmp_tgt;
            wr   = 1'b1;
            widx = REG_RA;
            wval = pc4;
          end
          OP_BEQ: begin
            if (opa == opb) begin
              npc = br_tgt;
            end
          end
          OP_BNE: begin
            if (opa != opb) begin
              npc = br_tgt;
            end
          end
          OP_BGTZ: begin
            if (lt_signed('0, opa)) begin
              npc = br_tgt;
            end
          end
          OP_LW: begin
            ld    = 1'b1;
            wr    = 1'b1;
            widx  = s1_rt;
          end
          OP_LH, OP_LHU: begin
            ld    = 1'b1;
            wr    = 1'b1;
            widx  = s1_rt;
            msize = MS_HALF;
            msign = (s1_op == OP_LH);
          end
          OP_LB, OP_LBU: begin
            ld    = 1'b1;
            wr    = 1'b1;
            widx  = s1_rt;
            msize = MS_BYTE;
            msign = (s1_op == OP_LB);
          end
          OP_SW: begin
            st = 1'b1;
          end
          OP_SH: begin
            st    = 1'b1;
            msize = MS_HALF;
          end
          OP_SB: begin
            st    = 1'b1;
            msize = MS_BYTE;
          end
          // every other opcode is an immediate ALU op, unknown ones give zero
          default: begin
            wr   = 1'b1;
            widx = s1_rt;
            wval = alu_i(s1_op, opa, s1_imm);
          end
        endcase
      end
      // register zero is never written and is reported as no write
      if (wr && (widx == '0)) begin
        wr   = 1'b0;
        ld   = 1'b0;
        wval = '0;
      end
    end
  end

  // byte lane mapping: byte i of the access sits in lane (addr+i)%4, big-endian
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      lane_off[k]   = LANE_W'(k) - maddr[LANE_W-1:0];
      lane_on[k]    = (lane_off[k] <= msize);
      lane_sel[k]   = msize - lane_off[k];
      lane_row[k]   = maddr[AW-1:LANE_W] + RW'(LANE_W'(k) < maddr[LANE_W-1:0]);
      lane_wdata[k] = sdata[8*lane_sel[k] +: 8];
    end
  end

  assign dm_ctl.rd_en = s1_adv && ld;
  assign dm_ctl.wr_en = (s1_adv && st) ? lane_on : '0;

  mse_dmem #(
    .DATA_BYTES(DATA_BYTES)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (dm_ctl),
    .row_i     (lane_row),
    .wdata_i   (lane_wdata),
    .rdata_o   (dm_rdata),
    .clr_busy_o(clr_busy)
  );

  // pc and halt flag; a start_pc write also restarts a halted unit
  always_comb begin
    pc_d   = pc_q;
    halt_d = halt_q;
    if (cfg_we_i && (cfg_idx_i == CFG_START_PC)) begin
      pc_d   = cfg_data_i;
      halt_d = 1'b0;
    end else if (s1_adv) begin
      pc_d   = npc;
      halt_d = halt_nx;
    end
  end

  // ---------------------------------------------------------------- output stage
  // rotate the bank outputs back into access order
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      ld_byte[k] = dm_rdata[LANE_W'(k) + s2_off_q];
    end
  end

  always_comb begin
    unique case (s2_size_q)
      MS_BYTE: ld_val = {{(XLEN-8){s2_sign_q & ld_byte[0][7]}}, ld_byte[0]};
      MS_HALF: ld_val = {{(XLEN-16){s2_sign_q & ld_byte[0][7]}}, ld_byte[0], ld_byte[1]};
      default: ld_val = {ld_byte[0], ld_byte[1], ld_byte[2], ld_byte[3]};
    endcase
  end

  assign s2_res_val = s2_load_q ? ld_val : s2_val_q;

  assign out_valid_o              = s2_vld_q;
  assign out_req_o.next_pc        = s2_pc_q;
  assign out_req_o.halted         = s2_halt_q;
  assign out_req_o.wrote_register = s2_wr_q;
  assign out_req_o.written_index  = s2_idx_q;
  assign out_req_o.written_value  = s2_res_val;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      pc_q      <= '0;
      halt_q    <= 1'b0;
      byp_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      pc_q      <= pc_d;
      halt_q    <= halt_d;
      byp_vld_q <= byp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q  <= in_req_i;
      byp_idx_q <= rf_wr.idx;
      byp_val_q <= rf_wr.data;
    end
    if (s1_adv) begin
      s2_pc_q   <= npc;
      s2_halt_q <= halt_nx;
      s2_wr_q   <= wr;
      s2_idx_q  <= widx;
      s2_val_q  <= wval;
      s2_load_q <= ld;
      s2_size_q <= msize;
      s2_sign_q <= msign;
      s2_off_q  <= maddr[LANE_W-1:0];
    end
  end

  // ---------------------------------------------------------------- checks
  `MSE_ASSERT(a_halt_freezes_pc, (s1_adv && halt_q && !cfg_we_i) |=> (halt_q && (pc_q == $past(pc_q))), "halted unit changed state")
  `MSE_ASSERT(a_rf_write_on_handoff, rf_wr.en |-> (out_accept || cfg_we_i), "register write without result handoff")
  `MSE_ASSERT(a_dmem_write_on_advance, (|dm_ctl.wr_en) |-> (s1_adv && !halt_q && !clr_busy), "memory write outside execute")

endmodule

`default_nettype wire
